// ===== design/utd_pkg.sv =====
// Shared types, constants and the lead byte classifier for the UTF-8 to UCS-2 decoder.
// No dependencies; used by utd_step and utf8_to_ucs2_decoder.
package utd_pkg;

    // Lead byte class patterns and payload masks
    localparam logic [7:0] ASCII_KEEP  = 8'h7f;
    localparam logic [7:0] LEAD2_MASK  = 8'he0;
    localparam logic [7:0] LEAD2_TAG   = 8'hc0;
    localparam logic [7:0] LEAD2_KEEP  = 8'h1f;
    localparam logic [7:0] LEAD3_MASK  = 8'hf0;
    localparam logic [7:0] LEAD3_TAG   = 8'he0;
    localparam logic [7:0] LEAD3_KEEP  = 8'h0f;
    localparam logic [7:0] LEAD4_MASK  = 8'hf8;
    localparam logic [7:0] LEAD4_TAG   = 8'hf0;
    localparam logic [7:0] LEAD4_KEEP  = 8'h07;
    localparam logic [7:0] LEAD5_MASK  = 8'hfc;
    localparam logic [7:0] LEAD5_TAG   = 8'hf8;
    localparam logic [7:0] LEAD5_KEEP  = 8'h03;
    localparam logic [7:0] LEAD6_MASK  = 8'hfe;
    localparam logic [7:0] LEAD6_TAG   = 8'hfc;
    localparam logic [7:0] LEAD6_KEEP  = 8'h01;
    localparam logic [7:0] NUL_BYTE    = 8'h00;

    // Continuation byte: top two bits 10, six payload bits
    localparam logic [1:0] CONT_TAG    = 2'b10;

    // Sequence lengths; zero marks an invalid lead
    localparam logic [2:0] LEN_BAD     = 3'd0;
    localparam logic [2:0] LEN_ONE     = 3'd1;
    localparam logic [2:0] LEN_TWO     = 3'd2;
    localparam logic [2:0] LEN_THREE   = 3'd3;
    localparam logic [2:0] LEN_FOUR    = 3'd4;
    localparam logic [2:0] LEN_FIVE    = 3'd5;
    localparam logic [2:0] LEN_SIX     = 3'd6;

    localparam int UNIT_W = 16;

    typedef struct packed {
        logic [2:0] len;
        logic [7:0] keep;
    } lead_info_t;

    // One result item
    typedef struct packed {
        logic [UNIT_W-1:0] code_unit;
        logic              unit_valid;
        logic              done_res;
        logic              bad_sequence;
        logic [UNIT_W-1:0] unit_count;
    } result_t;

    // Classify a lead byte: sequence length and payload mask
    function automatic lead_info_t lead_decode(input logic [7:0] b);
        lead_info_t info;
        info.len  = LEN_BAD;
        info.keep = 8'h00;
        priority if (b[7] == 1'b0) begin
            info.len  = LEN_ONE;
            info.keep = ASCII_KEEP;
        end
        else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
            info.len  = LEN_TWO;
            info.keep = LEAD2_KEEP;
        end
        else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
            info.len  = LEN_THREE;
            info.keep = LEAD3_KEEP;
        end
        else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
            info.len  = LEN_FOUR;
            info.keep = LEAD4_KEEP;
        end
        else if ((b & LEAD5_MASK) == LEAD5_TAG) begin
            info.len  = LEN_FIVE;
            info.keep = LEAD5_KEEP;
        end
        else if ((b & LEAD6_MASK) == LEAD6_TAG) begin
            info.len  = LEN_SIX;
            info.keep = LEAD6_KEEP;
        end
        else begin
            info.len  = LEN_BAD;
            info.keep = 8'h00;
        end
        return info;
    endfunction

endpackage

// ===== design/utd_step.sv =====
// Decoder state (accumulator, bytes left, unit count) and the per-byte
// decode step. Depends on utd_pkg.
module utd_step #(
    parameter int COUNT_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,       // byte consumed this cycle
    input  logic [7:0]                    in_byte,
    input  logic [utd_pkg::UNIT_W-1:0]    max_units,
    output logic                          has_result,
    output utd_pkg::result_t              result
);

    localparam int CMP_W = (COUNT_BITS > utd_pkg::UNIT_W) ? COUNT_BITS : utd_pkg::UNIT_W;

    logic [utd_pkg::UNIT_W-1:0] acc_reg, acc_next;
    logic [2:0]                 bl_reg, bl_next;
    logic [COUNT_BITS-1:0]      ud_reg, ud_next, ud_inc;
    logic [CMP_W-1:0]           ud_ext, ud_inc_ext, max_ext;
    utd_pkg::lead_info_t        lead;
    logic                       char_done;
    logic                       end_str;
    logic                       bad;

    assign ud_inc     = ud_reg + COUNT_BITS'(1);
    assign ud_ext     = CMP_W'(ud_reg);
    assign ud_inc_ext = CMP_W'(ud_inc);
    assign max_ext    = CMP_W'(max_units);
    assign lead       = utd_pkg::lead_decode(in_byte);

    // Next state and result for the byte at hand
    always_comb
    begin
        acc_next   = acc_reg;
        bl_next    = bl_reg;
        ud_next    = ud_reg;
        char_done  = 1'b0;
        end_str    = 1'b0;
        bad        = 1'b0;
        has_result = 1'b0;
        result     = '0;
        if (bl_reg == 3'd0)
        begin
            if (in_byte == utd_pkg::NUL_BYTE)
            begin
                end_str = 1'b1;
            end
            else if (lead.len == utd_pkg::LEN_BAD)
            begin
                end_str = 1'b1;
                bad     = 1'b1;
            end
            else
            begin
                acc_next = {8'h00, in_byte & lead.keep};
                if (lead.len == utd_pkg::LEN_ONE)
                    char_done = 1'b1;
                else
                    bl_next = lead.len - 3'd1;
            end
        end
        else
        begin
            if (in_byte[7:6] != utd_pkg::CONT_TAG)
            begin
                end_str = 1'b1;
                bad     = 1'b1;
            end
            else
            begin
                acc_next = {acc_reg[9:0], in_byte[5:0]};
                bl_next  = bl_reg - 3'd1;
                if (bl_next == 3'd0)
                    char_done = 1'b1;
            end
        end

        // Completed character: emit it unless the limit is reached
        if (char_done)
        begin
            if (ud_ext >= max_ext)
            begin
                end_str = 1'b1;
            end
            else
            begin
                has_result        = 1'b1;
                result.code_unit  = acc_next;
                result.unit_valid = 1'b1;
                result.unit_count = ud_inc_ext[utd_pkg::UNIT_W-1:0];
                ud_next           = ud_inc;
                acc_next          = '0;
            end
        end

        // End of string: done item, clear state
        if (end_str)
        begin
            has_result          = 1'b1;
            result.done_res     = 1'b1;
            result.bad_sequence = bad;
            result.unit_count   = ud_ext[utd_pkg::UNIT_W-1:0];
            acc_next            = '0;
            bl_next             = 3'd0;
            ud_next             = '0;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            bl_reg  <= 3'd0;
            ud_reg  <= '0;
        end
        else if (fire)
        begin
            acc_reg <= acc_next;
            bl_reg  <= bl_next;
            ud_reg  <= ud_next;
        end
    end

    // A finished string leaves the decoder clear
    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && has_result && result.done_res) |=> (bl_reg == 3'd0 && ud_reg == '0))
        else $error("state not cleared after end of string");

    // Mid-sequence bytes never produce an item
    a_mid_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (bl_next != 3'd0 && !end_str) |-> !has_result)
        else $error("item produced mid-sequence");

endmodule

// ===== design/utf8_to_ucs2_decoder.sv =====
// Top level: stream ports, input register, max_units register, result
// register. Depends on utd_pkg and utd_step.
// An accepted byte yields its item through the input register, then the
// result register. Throughput: one byte per cycle unless stalled, set by the
// single decode step between the two registers. A full result register that
// is not taken stalls only bytes that produce an item.
// Reset (rst_n, async low): decoder state cleared, no items held,
// max_units = 65535.
module utf8_to_ucs2_decoder #(
    parameter int COUNT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [15:0] code_unit, [31:16] unit_count
    output logic [1:0]  m_tuser,    // [0] unit_valid, [1] bad_sequence
    output logic        m_tlast,    // done_res
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata   // max_units
);

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic [15:0]            max_units_reg;
    logic                   out_valid_reg;
    utd_pkg::result_t       out_reg;
    logic                   has_result;
    utd_pkg::result_t       result;
    logic                   out_free;
    logic                   fire;

    // Handshake: a byte moves on when its item (if any) has room
    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && (out_free || !has_result);
    assign s_tready = !in_valid_reg || fire;

    utd_step #(
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .in_byte    (in_byte_reg),
        .max_units  (max_units_reg),
        .has_result (has_result),
        .result     (result)
    );

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_units_reg <= 16'hffff;
        else if (cfg_we)
            max_units_reg <= cfg_wdata;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_byte_reg <= s_tdata;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire && has_result)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire && has_result)
            out_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.unit_count, out_reg.code_unit};
    assign m_tuser  = {out_reg.bad_sequence, out_reg.unit_valid};
    assign m_tlast  = out_reg.done_res;

    // Done items carry no code unit
    a_done_no_unit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> !m_tuser[0])
        else $error("done item flagged as code unit");

    // Non-done items are always code units
    a_unit_or_done: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> (m_tuser[0] && !m_tuser[1]))
        else $error("item is neither code unit nor done");

    // A stalled item never gets overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !(fire && has_result))
        else $error("result register overwritten while held");

endmodule
